// ===== hw/rtl/lawt_pkg.sv =====
// Shared types, codes and defaults for the lockstep ack window tracker.
package lawt_pkg;

  // Window half-size default (the window spans 2*DELAY steps).
  localparam int DELAY_DEFAULT = 8;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_PACKET_MAGIC = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RESEND_WAIT  = 1'd1;

  localparam logic [31:0] PACKET_MAGIC_RST = 32'd0;
  localparam logic [7:0]  RESEND_WAIT_RST  = 8'd5;

  // Item commands; code 3 is unused and yields an all-zero result.
  localparam logic [1:0] CMD_HEADER = 2'd0;
  localparam logic [1:0] CMD_STEP   = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;

  // Header check status.
  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_BAD_MAGIC  = 2'd1;
  localparam logic [1:0] STAT_OUT_WINDOW = 2'd2;
  localparam logic [1:0] STAT_DUPLICATE  = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] hdr_magic;
    logic [31:0] hdr_step;
    logic [31:0] hdr_ack;
  } lawt_req_t;

  typedef struct packed {
    logic [1:0]  packet_status;
    logic [4:0]  store_slot;
    logic        resend_valid;
    logic [31:0] resend_step;
    logic        advanced;
    logic        deliver_valid;
    logic [31:0] deliver_step;
    logic [31:0] next_step;
    logic [31:0] next_recv_bits;
  } lawt_rsp_t;

  typedef struct packed {
    logic [31:0] packet_magic;
    logic [7:0]  resend_wait_ticks;
  } lawt_cfg_t;

endpackage

// ===== hw/rtl/lawt_stream_if.sv =====
// Valid/ready item channel carrying one payload struct.
interface lawt_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/lawt_core.sv =====
// Window state registers and the single-pass header/step/tick logic.
module lawt_core #(
  parameter int DELAY = lawt_pkg::DELAY_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  lawt_pkg::lawt_req_t item,
  input  lawt_pkg::lawt_cfg_t cfg,
  output lawt_pkg::lawt_rsp_t result
);

  localparam int WIN        = 2 * DELAY;
  localparam int INIT_LIMIT = (WIN > 31) ? 31 : WIN;

  localparam logic [4:0]         DELAY_V5   = 5'(DELAY);
  localparam logic [5:0]         DELAY_V6   = 6'(DELAY);
  localparam logic [31:0]        DELAY_V32  = 32'(DELAY);
  localparam logic signed [32:0] DELAY_S33  = 33'(DELAY);
  localparam logic signed [6:0]  WIN_S7     = 7'(WIN);
  localparam logic [4:0]         INIT_LIM_V = 5'(INIT_LIMIT);
  localparam logic [4:0]         SLOT_LAST  = 5'(WIN - 1);

  logic [31:0] step_count, step_count_next;
  logic [4:0]  slot_base, slot_base_next;   // step_count mod 2*DELAY
  logic [31:0] recv_bits, recv_bits_next;
  logic [31:0] ack_bits, ack_bits_next;
  logic [4:0]  init_count, init_count_next;
  logic        waiting_flag, waiting_flag_next;
  logic [7:0]  wait_ticks, wait_ticks_next;

  // Header path
  logic signed [32:0] offset;
  logic               in_window;
  logic signed [5:0]  off6;
  logic [5:0]         pos;
  logic               pos_ok;
  logic               dup;
  logic [4:0]         off_mag;
  logic [31:0]        ack_shifted;
  logic signed [6:0]  slot_sum;
  logic signed [6:0]  slot_fix;

  // Step path
  logic [31:0] base;
  logic        init_full;
  logic        empty_case;
  logic [4:0]  start_idx;
  logic [4:0]  end_idx;
  logic [31:0] range_mask;
  logic [31:0] cand;
  logic [31:0] lowest;
  logic [4:0]  hole_idx;
  logic        stall;

  always_comb begin
    offset    = $signed({1'b0, item.hdr_step}) - $signed({1'b0, step_count});
    in_window = (offset <= DELAY_S33) && (offset >= -DELAY_S33);
    off6      = offset[5:0];
    pos       = DELAY_V6 + offset[5:0];
    pos_ok    = !pos[5];
    dup       = pos_ok && recv_bits[pos[4:0]];
    off_mag   = off6[5] ? 5'(-off6) : off6[4:0];
    ack_shifted = off6[5] ? (item.hdr_ack >> off_mag) : (item.hdr_ack << off_mag);
    slot_sum  = $signed({2'b00, slot_base}) + 7'(off6);
    if (slot_sum < 0) begin
      slot_fix = slot_sum + WIN_S7;
    end else if (slot_sum >= WIN_S7) begin
      slot_fix = slot_sum - WIN_S7;
    end else begin
      slot_fix = slot_sum;
    end
  end

  always_comb begin
    base       = step_count - DELAY_V32;
    init_full  = init_count >= DELAY_V5;
    empty_case = (ack_bits == 32'd0) && init_full;
    start_idx  = init_full ? 5'd0 : DELAY_V5 - init_count;
    end_idx    = init_full ? init_count : DELAY_V5;
    range_mask = ((32'd1 << end_idx) - 32'd1) & ~((32'd1 << start_idx) - 32'd1);
    cand       = ~ack_bits & range_mask;
    lowest     = cand & (~cand + 32'd1);
    hole_idx   = 5'd0;
    for (int j = 0; j < 32; j++) begin
      if (lowest[j]) hole_idx = hole_idx | 5'(j);
    end
    stall = init_full && !recv_bits[0];
  end

  always_comb begin
    step_count_next   = step_count;
    slot_base_next    = slot_base;
    recv_bits_next    = recv_bits;
    ack_bits_next     = ack_bits;
    init_count_next   = init_count;
    waiting_flag_next = waiting_flag;
    wait_ticks_next   = wait_ticks;
    result            = '0;

    case (item.command)
      lawt_pkg::CMD_HEADER: begin
        if (item.hdr_magic != cfg.packet_magic) begin
          result.packet_status = lawt_pkg::STAT_BAD_MAGIC;
        end else if (!in_window) begin
          result.packet_status = lawt_pkg::STAT_OUT_WINDOW;
        end else if (dup) begin
          result.packet_status = lawt_pkg::STAT_DUPLICATE;
        end else begin
          result.packet_status = lawt_pkg::STAT_OK;
          result.store_slot    = slot_fix[4:0];
          if (pos_ok) recv_bits_next = recv_bits | (32'd1 << pos[4:0]);
          ack_bits_next = ack_bits | ack_shifted;
        end
      end
      lawt_pkg::CMD_STEP: begin
        if (empty_case) begin
          if (waiting_flag && (wait_ticks > cfg.resend_wait_ticks)) begin
            result.resend_valid = 1'b1;
            result.resend_step  = base;
          end
        end else if (cand != 32'd0) begin
          result.resend_valid = 1'b1;
          result.resend_step  = base + 32'(hole_idx);
        end
        if (stall) begin
          if (!waiting_flag) begin
            waiting_flag_next = 1'b1;
            wait_ticks_next   = 8'd0;
          end
        end else begin
          waiting_flag_next = 1'b0;
          wait_ticks_next   = 8'd0;
          result.advanced   = 1'b1;
          if (init_full) begin
            result.deliver_valid = 1'b1;
            result.deliver_step  = base;
          end
          step_count_next = step_count + 32'd1;
          // Slot base restarts at the end of the ring or when the step counter wraps.
          if (step_count == '1 || slot_base == SLOT_LAST) begin
            slot_base_next = 5'd0;
          end else begin
            slot_base_next = slot_base + 5'd1;
          end
          if (init_count < INIT_LIM_V) init_count_next = init_count + 5'd1;
          recv_bits_next        = recv_bits >> 1;
          ack_bits_next         = ack_bits >> 1;
          result.next_step      = step_count + 32'd1;
          result.next_recv_bits = recv_bits >> 1;
        end
      end
      lawt_pkg::CMD_TICK: begin
        if (waiting_flag && wait_ticks != 8'hFF) wait_ticks_next = wait_ticks + 8'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_count   <= '0;
      slot_base    <= '0;
      recv_bits    <= '0;
      ack_bits     <= '0;
      init_count   <= '0;
      waiting_flag <= 1'b0;
      wait_ticks   <= '0;
    end else if (fire) begin
      step_count   <= step_count_next;
      slot_base    <= slot_base_next;
      recv_bits    <= recv_bits_next;
      ack_bits     <= ack_bits_next;
      init_count   <= init_count_next;
      waiting_flag <= waiting_flag_next;
      wait_ticks   <= wait_ticks_next;
    end
  end

  // A stall can only start once the window has filled.
  a_wait_needs_full: assert property (@(posedge clk) disable iff (rst)
    waiting_flag |-> init_count >= DELAY_V5)
    else $error("waiting with partial window");

  a_init_bound: assert property (@(posedge clk) disable iff (rst)
    init_count <= INIT_LIM_V)
    else $error("init_count past limit");

  a_step_inc: assert property (@(posedge clk) disable iff (rst)
    fire && item.command == lawt_pkg::CMD_STEP && result.advanced
    |=> step_count == $past(step_count) + 32'd1 && !waiting_flag)
    else $error("advance did not bump step");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    slot_base <= SLOT_LAST)
    else $error("slot base out of ring");

endmodule

// ===== hw/rtl/lockstep_ack_window_tracker.sv =====
// Top level: config registers, input register, core and result register.
//
//   channel | dir | handshake     | payload
//   req     | in  | valid/ready   | command, hdr_magic, hdr_step, hdr_ack
//   rsp     | out | valid/ready   | packet_status .. next_recv_bits
//   cfg     | in  | cfg_we only   | cfg_index, cfg_wdata
//
// One item per cycle sustained while rsp takes results; accept loads the input
// register, and the item then moves into the result register, where it shows valid.
// Window state updates as the item moves from the input to the result register.
// Reset is synchronous: window state cleared, magic 0, resend wait 5.
// rsp stall holds the result register; req keeps taking items while the
// input stage is empty or can drain into a free or emptying result register.
module lockstep_ack_window_tracker #(
  parameter int DELAY = lawt_pkg::DELAY_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [lawt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lawt_pkg::CFG_DATA_W-1:0] cfg_wdata,
  lawt_stream_if.sink                    req,
  lawt_stream_if.source                  rsp
);

  lawt_pkg::lawt_cfg_t cfg;

  // Input register
  logic                s1_valid;
  lawt_pkg::lawt_req_t s1_item;
  logic                s1_move;

  // Result register
  logic                out_valid;
  lawt_pkg::lawt_rsp_t out_data;
  lawt_pkg::lawt_rsp_t core_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.packet_magic      <= lawt_pkg::PACKET_MAGIC_RST;
      cfg.resend_wait_ticks <= lawt_pkg::RESEND_WAIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lawt_pkg::REG_PACKET_MAGIC: cfg.packet_magic      <= cfg_wdata[31:0];
        lawt_pkg::REG_RESEND_WAIT:  cfg.resend_wait_ticks <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Input stage drains when the result register is empty or being taken.
  assign s1_move   = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.valid && req.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) s1_item <= req.data;
  end

  lawt_core #(
    .DELAY (DELAY)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (s1_move),
    .item   (s1_item),
    .cfg    (cfg),
    .result (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) out_data <= core_result;
  end

  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

endmodule
